FILE: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,     // taking message bytes
    S_PAD80,    // append the 0x80 marker byte
    S_PADZ,     // zero fill up to byte 56 of a block
    S_PADLEN,   // append the 64-bit bit length
    S_SCHED,    // compute next schedule word
    S_ROUND,    // one compression round
    S_FOLD,     // add working words into the chaining value
    S_OUT       // deliver the eight digest words
  } sha_state_t;

  typedef logic [31:0] word_t;

  localparam int unsigned NUM_ROUNDS  = 64;
  localparam int unsigned NUM_WORDS   = 8;
  localparam int unsigned WINDOW_LEN  = 16;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_BYTE_POS  = 6'd56;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [5:0] SCHED_START   = 6'd16;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] PAD_ZERO = 8'h00;

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_HASH [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Rotate right by a constant amount in 1..31
  function automatic word_t ror(input word_t x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: hdl/sha256_in_if.sv
// ----------------------------------------------------------------------------
// sha256_in_if
// Message byte channel: one byte request per handshake plus end marker.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output message_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input message_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

FILE: hdl/sha256_out_if.sv
// ----------------------------------------------------------------------------
// sha256_out_if
// Digest channel: one 32-bit digest word request per handshake.
// ----------------------------------------------------------------------------
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

FILE: hdl/sha256_hash.sv
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 digest of a byte stream, with a schedule step before each round on one round unit.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : byte requests. byte_present marks a data byte; end_of_message
//            closes the message (with or without a byte on that request).
//   digest : eight 32-bit words, word_index 0 (most significant) first,
//            last_word set on the eighth.
// Throughput: msg.ready is high while collecting bytes, one byte per cycle.
//   Each completed 64-byte block stalls the input for 64 rounds, each a
//   schedule word step and then the round on the shared adder chain, and
//   for the fold into the chaining value.
// After the end request: padding is written one byte per cycle, pausing
//   before the length bytes and while a filled block is compressed (one or
//   two block compressions in all), then the eight words are offered. The
//   input stays stalled until the last word is taken.
// Receiver stall: digest words are held in the chaining registers and
//   simply wait; nothing is lost.
// Reset: synchronous rst returns the chaining value to the initial hash,
//   clears the length and fill position; the block is ready next cycle.
// ----------------------------------------------------------------------------
module sha256_hash
  import sha256_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sha256_in_if.sink     msg,
  sha256_out_if.source  digest
);

  // Sequencer and datapath registers
  sha_state_t  state, state_next;
  sha_state_t  ret_state, ret_next;
  logic [5:0]  pos;          // fill position in the current block
  logic [60:0] len_bytes;    // message bytes taken, wraps
  logic [23:0] word_acc;     // last three bytes of the word being assembled
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  word_t       chain  [NUM_WORDS];
  word_t       rw     [NUM_WORDS];
  word_t       window [WINDOW_LEN];
  word_t       w_reg;

  // Control outputs of the sequencer
  logic        push_en;
  logic [7:0]  push_byte;
  logic        in_take;
  logic        out_take;

  logic [63:0] msg_bits;
  logic [2:0]  len_sel;
  logic        block_full;

  assign msg_bits   = {len_bytes, 3'b000};
  assign len_sel    = 3'd7 - pos[2:0];
  assign block_full = (pos == LAST_BYTE_POS);
  assign in_take    = msg.valid && msg.ready;
  assign out_take   = digest.valid && digest.ready;

  // Next state
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          ret_next = msg.end_of_message ? S_PAD80 : S_IDLE;
          if (msg.byte_present && block_full) begin
            state_next = S_SCHED;
          end else begin
            state_next = ret_next;
          end
        end
      end
      S_PAD80: begin
        ret_next   = S_PADZ;
        state_next = block_full ? S_SCHED : S_PADZ;
      end
      S_PADZ: begin
        ret_next = S_PADZ;
        if (pos == LEN_BYTE_POS) begin
          state_next = S_PADLEN;
        end else if (block_full) begin
          state_next = S_SCHED;
        end
      end
      S_PADLEN: begin
        ret_next = S_OUT;
        if (block_full) begin
          state_next = S_SCHED;
        end
      end
      S_SCHED: state_next = S_ROUND;
      S_ROUND: state_next = (rnd == LAST_ROUND) ? S_FOLD : S_SCHED;
      S_FOLD:  state_next = ret_state;
      S_OUT: begin
        if (out_take && out_idx == LAST_WORD_IDX) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    push_en      = 1'b0;
    push_byte    = msg.message_byte;
    msg.ready    = 1'b0;
    digest.valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        msg.ready = 1'b1;
        push_en   = msg.valid && msg.byte_present;
      end
      S_PAD80: begin
        push_en   = 1'b1;
        push_byte = PAD_MARK;
      end
      S_PADZ: begin
        push_en   = (pos != LEN_BYTE_POS);
        push_byte = PAD_ZERO;
      end
      S_PADLEN: begin
        push_en   = 1'b1;
        push_byte = msg_bits[{len_sel, 3'b000} +: 8];
      end
      S_OUT:   digest.valid = 1'b1;
      default: ;
    endcase
  end

  assign digest.digest_word = chain[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == LAST_WORD_IDX);

  // Schedule word from the rolling window taps
  word_t w_calc;
  always_comb begin
    if (rnd < SCHED_START) begin
      w_calc = window[0];
    end else begin
      w_calc = window[0] + small_sigma0(window[1]) + window[9]
             + small_sigma1(window[14]);
    end
  end

  // Round function on the working words
  word_t t1, t2;
  always_comb begin
    t1 = rw[7] + big_sigma1(rw[4]) + ((rw[4] & rw[5]) ^ (~rw[4] & rw[6]))
       + ROUND_K[rnd] + w_reg;
    t2 = big_sigma0(rw[0])
       + ((rw[0] & rw[1]) ^ (rw[0] & rw[2]) ^ (rw[1] & rw[2]));
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_IDLE;
      pos       <= '0;
      len_bytes <= '0;
      rnd       <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      if (push_en) begin
        pos <= pos + 6'd1;
      end
      if (in_take && msg.byte_present) begin
        len_bytes <= len_bytes + 61'd1;
      end
      if (state == S_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (out_take) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_WORD_IDX) begin
          pos       <= '0;
          len_bytes <= '0;
        end
      end
    end
  end

  // Chaining value: initial hash at reset and after each digest
  always_ff @(posedge clk) begin
    if (rst || (out_take && out_idx == LAST_WORD_IDX)) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= INIT_HASH[i];
      end
    end else if (state == S_FOLD) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain[i] <= chain[i] + rw[i];
      end
    end
  end

  // Byte assembly, schedule window and working words
  always_ff @(posedge clk) begin
    if (push_en) begin
      word_acc <= {word_acc[15:0], push_byte};
      if (pos[1:0] == 2'd3) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          window[i] <= window[i + 1];
        end
        window[WINDOW_LEN - 1] <= {word_acc, push_byte};
      end
      // Block complete: load working words for the compression
      if (block_full) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          rw[i] <= chain[i];
        end
      end
    end
    if (state == S_SCHED) begin
      w_reg <= w_calc;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        window[i] <= window[i + 1];
      end
      window[WINDOW_LEN - 1] <= w_calc;
    end
    if (state == S_ROUND) begin
      rw[7] <= rw[6];
      rw[6] <= rw[5];
      rw[5] <= rw[4];
      rw[4] <= rw[3] + t1;
      rw[3] <= rw[2];
      rw[2] <= rw[1];
      rw[1] <= rw[0];
      rw[0] <= t1 + t2;
    end
  end

endmodule

FILE: tb/sha256_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_checker
// Watches the message and digest channels of the hash engine, computes the
// SHA-256 digest of every message it sees go in, and compares each digest
// word that comes out against the oldest word still owed.
// ----------------------------------------------------------------------------
module sha256_checker (
  input  logic  clk,
  input  logic  rst,
  sha256_in_if  msg,
  sha256_out_if digest,
  output int    fail_count,
  output int    pending,
  output int    messages,
  output int    words_checked,
  output int    two_block_pads,
  output int    longest_msg
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam bit [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Predicted engine state
  bit [31:0]    hv [8];
  bit [7:0]     blk_bytes [64];
  bit [63:0]    bit_count;
  digest_word_t digest_q [$];

  function automatic bit [31:0] rotr(input bit [31:0] x, input int unsigned n);
    bit [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // One full compression of blk_bytes into hv
  function automatic void compress_block();
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + K_TAB[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
  endfunction

  function automatic void clear_hash_state();
    hv        = IV;
    bit_count = '0;
  endfunction

  // Absorb one accepted request; an end request closes the message
  function automatic void take_request(input logic [7:0] b, input logic has_byte,
                                       input logic is_end);
    int unsigned  pos;
    digest_word_t dw;
    if (has_byte) begin
      pos = bit_count[8:3];
      blk_bytes[pos] = b;
      bit_count += 64'd8;
      if (pos == 63) compress_block();
    end
    if (!is_end) return;

    messages++;
    if (int'(bit_count >> 3) > longest_msg) longest_msg = int'(bit_count >> 3);

    // marker byte and zero fill; no room for the length means an extra block
    pos = bit_count[8:3];
    blk_bytes[pos] = 8'h80;
    for (int i = pos + 1; i < 64; i++) blk_bytes[i] = 8'h00;
    if (pos >= 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
      two_block_pads++;
    end
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_count[63-8*i -: 8];
    compress_block();

    for (int i = 0; i < 8; i++) begin
      dw.word = hv[i];
      dw.idx  = 3'(i);
      dw.last = (i == 7);
      digest_q = {digest_q, dw};
    end
    clear_hash_state();
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Watch both channels at each edge
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      clear_hash_state();
      digest_q.delete();
    end else begin
      if (msg.valid && msg.ready)
        take_request(msg.message_byte, msg.byte_present, msg.end_of_message);
      if (digest.valid && digest.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("digest word %h (index %0d) with nothing owed",
                                    digest.digest_word, digest.word_index));
        end else begin
          exp_w = digest_q.pop_front();
          words_checked++;
          if (digest.digest_word !== exp_w.word)
            report_mismatch($sformatf("digest_word index %0d: got %h, want %h",
                                      exp_w.idx, digest.digest_word, exp_w.word));
          if (digest.word_index !== exp_w.idx)
            report_mismatch($sformatf("word_index: got %0d, want %0d",
                                      digest.word_index, exp_w.idx));
          if (digest.last_word !== exp_w.last)
            report_mismatch($sformatf("last_word index %0d: got %b, want %b",
                                      exp_w.idx, digest.last_word, exp_w.last));
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives message requests into the SHA-256 engine through directed edge
// cases, one long message spanning a full block and a two-block pad, and
// short random messages under phases of sender idling, receiver stalls and
// one long receiver hold.
// The checker beside the engine predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    PH_FREE,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE,
    PH_HOLD
  } idle_phase_e;

  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 10;
  localparam int DRAIN_CYCLES = 50;
  localparam int LONG_LEN     = 120;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] in_byte    = 8'h00;
  logic       in_present = 1'b0;
  logic       in_end     = 1'b0;
  logic       out_ready  = 1'b0;

  idle_phase_e idle_phase = PH_FREE;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int items_sent = 0;

  int fail_count, pending, messages, words_checked, two_block_pads, longest_msg;

  sha256_in_if  msg_ch ();
  sha256_out_if dig_ch ();

  assign msg_ch.valid          = in_valid;
  assign msg_ch.message_byte   = in_byte;
  assign msg_ch.byte_present   = in_present;
  assign msg_ch.end_of_message = in_end;
  assign dig_ch.ready          = out_ready;

  sha256_hash DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  sha256_checker chk (
    .clk            (clk),
    .rst            (rst),
    .msg            (msg_ch),
    .digest         (dig_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .messages       (messages),
    .words_checked  (words_checked),
    .two_block_pads (two_block_pads),
    .longest_msg    (longest_msg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Digest receiver: random stalls, plus one long hold when that phase starts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (idle_phase == PH_HOLD && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One request; returns just after the edge that accepted it
  task automatic send_req(input logic [7:0] b, input logic has_byte, input logic is_end);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_present <= has_byte;
    in_end     <= is_end;
    @(negedge clk);
    while (!msg_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // A message of len bytes; fill < 0 means random content.
  // byte_on_end puts the last byte on the end request, else a bare end marker follows.
  task automatic send_message(input int len, input bit byte_on_end, input int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      // stray request with neither byte nor end
      if ($urandom_range(99) < 6) begin
        send_req(8'($urandom), 1'b0, 1'b0);
        items_sent++;
      end
      send_req(b, 1'b1, (i == len - 1) && byte_on_end);
      items_sent++;
    end
    if (len == 0 || !byte_on_end) begin
      send_req(8'($urandom), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  // Random short messages under one idling setting, until the phase budget is spent
  task automatic run_phase(input idle_phase_e ph, input int gap, input int stall);
    int start_items;
    int room;
    int len;
    int fill;
    idle_phase  = ph;
    gap_pct     = gap;
    stall_pct   = stall;
    start_items = items_sent;
    while (items_sent - start_items < PHASE_ITEMS) begin
      // leave room for a bare end marker
      room = PHASE_ITEMS - (items_sent - start_items) - 1;
      len  = $urandom_range(room);
      fill = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0) : -1;
      send_message(len, $urandom_range(1), fill);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, stray request, extreme bytes, both end styles
    send_message(0, 1'b0, -1);
    send_req(8'hA5, 1'b0, 1'b0);
    items_sent++;
    send_message(1, 1'b1, 8'h00);
    send_message(1, 1'b0, 8'hFF);
    send_message(0, 1'b0, -1);
    send_message(3, 1'b1, -1);
    send_message(2, 1'b0, -1);

    // one full data block, then a marker at byte 56 that forces a second pad block
    send_message(LONG_LEN, 1'b1, -1);

    run_phase(PH_FREE, 0, 0);
    run_phase(PH_SENDER_IDLE, 72, 0);
    run_phase(PH_RECEIVER_STALL, 0, 72);
    run_phase(PH_BOTH_IDLE, 28, 28);

    // long receiver hold while requests keep coming
    idle_phase = PH_HOLD;
    gap_pct    = 0;
    stall_pct  = 0;
    send_message(4, 1'b1, -1);
    send_message(0, 1'b0, -1);
    send_message(6, 1'b0, -1);
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages (%0d needing an extra padding block, longest %0d bytes),",
             messages, two_block_pads, longest_msg);
    $display("%0d digest words compared over %0d requests in five idling phases.",
             words_checked, items_sent);
    if (pending != 0) $display("%0d expected digest words never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Run stopped: no progress within the time limit");
    $display("simulation failed");
    $finish;
  end

endmodule
